// ----- sv/clc_pkg.sv -----
// Shared types, constants and the quarter-wave sine builder for the cloth curl deformer.
package clc_pkg;

  localparam int unsigned SineEntriesDef = 256;
  localparam longint unsigned HalfPiQ28 = 64'd421657428;

  localparam int unsigned CoordW = 16;
  localparam int unsigned RxW    = 24;
  localparam int unsigned SineW  = 16;

  typedef enum logic [2:0] {
    RegPeriod = 3'd0,
    RegCosine = 3'd1,
    RegSine   = 3'd2,
    RegRadius = 3'd3,
    RegAmp    = 3'd4,
    RegWidth  = 3'd5,
    RegHeight = 3'd6
  } reg_idx_e;

  // Radius, width and height hold the values in use (zero already taken as one).
  typedef struct packed {
    logic        [15:0] period;
    logic signed [15:0] cosine;
    logic signed [15:0] sine;
    logic        [15:0] radius;
    logic        [15:0] amp;
    logic        [11:0] width;
    logic        [11:0] height;
  } cfg_t;

  // Taylor series to degree 13 in Q28, rounded to Q1.14 and clamped to one.
  // Evaluated at elaboration only, to fill the quarter-wave table.
  function automatic logic [14:0] sine_q14(input longint unsigned ang);
    longint unsigned sq;
    longint unsigned term;
    longint signed   sum;
    longint signed   e;
    sq   = (ang * ang) >> 28;
    term = ang;
    sum  = longint'(ang);
    term = ((term * sq) >> 28) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * sq) >> 28) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * sq) >> 28) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * sq) >> 28) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * sq) >> 28) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * sq) >> 28) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    e = (sum + 8192) / 16384;
    if (e > 16384) e = 16384;
    return 15'(e);
  endfunction

endpackage

// ----- sv/cloth_curl_vertex_deform.sv -----
// Top level of the cloth curl vertex deformer: configuration registers and pipeline.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  input    | in_valid_i/in_stall_o  | vertex_x_i, vertex_y_i
//  output   | out_valid_o/out_stall_i| grey_shade_o, vertex_depth_o
//  config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One vertex a cycle sustained while the output is not stalled. The path runs through the geometry stages,
// the bit-a-stage phase divider by the radius and the 15-stage width divider.
// Reset clears the registers to their defaults and empties the pipeline.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module cloth_curl_vertex_deform #(
  parameter int unsigned SineEntries = clc_pkg::SineEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         grey_shade_o,
  output logic signed [15:0] vertex_depth_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import clc_pkg::*;

  logic [15:0]        period_q, radius_q, amp_q;
  logic signed [15:0] cos_q, sin_q;
  logic [11:0]        width_q, height_q;
  cfg_t               cfg;
  logic               advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'd0;
      cos_q    <= 16'sd16384;
      sin_q    <= 16'sd0;
      radius_q <= 16'd512;
      amp_q    <= 16'd16384;
      width_q  <= 12'd256;
      height_q <= 12'd256;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegPeriod: period_q <= cfg_data_i;
        RegCosine: cos_q    <= $signed(cfg_data_i);
        RegSine:   sin_q    <= $signed(cfg_data_i);
        RegRadius: radius_q <= cfg_data_i;
        RegAmp:    amp_q    <= cfg_data_i;
        RegWidth:  width_q  <= cfg_data_i[11:0];
        RegHeight: height_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.period = period_q;
    cfg.cosine = cos_q;
    cfg.sine   = sin_q;
    cfg.radius = (radius_q == 16'd0) ? 16'd1 : radius_q;
    cfg.amp    = amp_q;
    cfg.width  = (width_q == 12'd0) ? 12'd1 : width_q;
    cfg.height = (height_q == 12'd0) ? 12'd1 : height_q;
  end

  // hold every stage while a result waits
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  logic                  g_valid, p_valid;
  logic signed [RxW-1:0] g_rx, p_rx;
  logic signed [SineW-1:0] p_sine;

  clc_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .x_i     (vertex_x_i),
    .y_i     (vertex_y_i),
    .valid_o (g_valid),
    .rx_o    (g_rx)
  );

  clc_phase #(
    .SineEntries (SineEntries)
  ) u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .radius_i (cfg.radius),
    .valid_i  (g_valid),
    .rx_i     (g_rx),
    .valid_o  (p_valid),
    .rx_o     (p_rx),
    .sine_o   (p_sine)
  );

  clc_light u_light (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .cfg_i          (cfg),
    .valid_i        (p_valid),
    .rx_i           (p_rx),
    .sine_i         (p_sine),
    .valid_o        (out_valid_o),
    .grey_shade_o   (grey_shade_o),
    .vertex_depth_o (vertex_depth_o)
  );

endmodule

// ----- sv/clc_geom.sv -----
// Curl centre offset, rotation and radius subtraction over three stages.
module clc_geom (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  clc_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  input  logic signed [15:0]         x_i,
  input  logic signed [15:0]         y_i,
  output logic                       valid_o,
  output logic signed [clc_pkg::RxW-1:0] rx_o
);
  import clc_pkg::*;

  logic signed [16:0] om;
  logic signed [29:0] cxp, cyp;
  logic signed [19:0] cx, cy;
  logic signed [20:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [36:0] pc_d, ps_d, pc_q, ps_q;
  logic signed [37:0] rot;
  logic signed [RxW-1:0] rx_d, rx_q;
  logic [2:0] vld_q;

  assign om   = 17'sd16384 - $signed({1'b0, cfg_i.period});
  assign cxp  = om * $signed({1'b0, cfg_i.width});
  assign cyp  = om * $signed({1'b0, cfg_i.height});
  assign cx   = 20'(cxp >>> 10);
  assign cy   = 20'(cyp >>> 10);
  assign dx_d = 21'(x_i) - 21'(cx);
  assign dy_d = 21'(y_i) - 21'(cy);

  assign pc_d = dx_q * cfg_i.cosine;
  assign ps_d = dy_q * cfg_i.sine;

  assign rot  = 38'(pc_q) - 38'(ps_q);
  assign rx_d = RxW'(rot >>> 14) - RxW'($signed({1'b0, cfg_i.radius}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      pc_q <= pc_d;
      ps_q <= ps_d;
      rx_q <= rx_d;
    end
  end

  assign valid_o = vld_q[2];
  assign rx_o    = rx_q;

endmodule

// ----- sv/clc_phase.sv -----
// Phase division by the radius, one quotient bit a stage, and quarter-wave sine lookup.
module clc_phase #(
  parameter int unsigned SineEntries = clc_pkg::SineEntriesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [15:0]                      radius_i,
  input  logic                             valid_i,
  input  logic signed [clc_pkg::RxW-1:0]   rx_i,
  output logic                             valid_o,
  output logic signed [clc_pkg::RxW-1:0]   rx_o,
  output logic signed [clc_pkg::SineW-1:0] sine_o
);
  import clc_pkg::*;

  localparam int unsigned NW    = $clog2(SineEntries + 1);
  localparam int unsigned PW    = RxW + NW;
  localparam int unsigned UW    = PW - 1;
  localparam int unsigned FourN = 4 * SineEntries;
  localparam int unsigned QW    = $clog2(FourN);
  localparam int unsigned IW    = $clog2(SineEntries + 1);

  logic [14:0] sine_tab [SineEntries + 1];

  for (genvar gi = 0; gi <= SineEntries; gi++) begin : g_tab
    localparam longint unsigned Ang = (HalfPiQ28 * longint'(gi)) / SineEntries;
    localparam logic [14:0] SineVal = sine_q14(Ang);
    assign sine_tab[gi] = SineVal;
  end

  // Divider stage registers; index 0 is the entry stage.
  logic [UW-1:0]     u_q   [UW+1];
  logic [15:0]       rem_q [UW+1];
  logic [QW-1:0]     q_q   [UW+1];
  logic              neg_q [UW+1];
  logic signed [RxW-1:0] rx_q [UW+1];
  logic              vld_q [UW+1];

  logic signed [PW-1:0] prod;
  assign prod = PW'(rx_i) * $signed(PW'(SineEntries));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // floor of a negative quotient is the complement of the quotient of the complement
      u_q[0]   <= prod[PW-1] ? UW'(~prod) : UW'(prod);
      neg_q[0] <= prod[PW-1];
      rem_q[0] <= '0;
      q_q[0]   <= '0;
      rx_q[0]  <= rx_i;
    end
  end

  for (genvar k = 0; k < UW; k++) begin : g_div
    logic [16:0] cand;
    logic        ge;
    logic [QW:0] q2;
    assign cand = {rem_q[k], u_q[k][UW-1-k]};
    assign ge   = cand >= {1'b0, radius_i};
    // keep the quotient modulo one full turn
    assign q2   = {q_q[k], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? 16'(cand - {1'b0, radius_i}) : 16'(cand);
        q_q[k+1]   <= (q2 >= (QW+1)'(FourN)) ? QW'(q2 - (QW+1)'(FourN)) : QW'(q2);
        u_q[k+1]   <= u_q[k];
        neg_q[k+1] <= neg_q[k];
        rx_q[k+1]  <= rx_q[k];
      end
    end
  end

  // Quadrant fold
  logic [QW:0]   qm, ph_a, ph;
  logic [IW-1:0] idx_d, idx_q;
  logic          sneg_d, sneg_q;
  logic signed [RxW-1:0] rxf_q, rxt_q;
  logic          vf_q, vt_q;
  logic signed [SineW-1:0] s_q;

  assign qm   = neg_q[UW] ? (QW+1)'(FourN - 1) - {1'b0, q_q[UW]} : {1'b0, q_q[UW]};
  assign ph_a = qm + (QW+1)'(3 * SineEntries);
  assign ph   = (ph_a >= (QW+1)'(FourN)) ? ph_a - (QW+1)'(FourN) : ph_a;

  always_comb begin
    if (ph < (QW+1)'(SineEntries)) begin
      idx_d  = IW'(ph);
      sneg_d = 1'b0;
    end else if (ph < (QW+1)'(2 * SineEntries)) begin
      idx_d  = IW'((QW+1)'(2 * SineEntries) - ph);
      sneg_d = 1'b0;
    end else if (ph < (QW+1)'(3 * SineEntries)) begin
      idx_d  = IW'(ph - (QW+1)'(2 * SineEntries));
      sneg_d = 1'b1;
    end else begin
      idx_d  = IW'((QW+1)'(FourN) - ph);
      sneg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vt_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= vld_q[UW];
      vt_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q  <= idx_d;
      sneg_q <= sneg_d;
      rxf_q  <= rx_q[UW];
      s_q    <= sneg_q ? -$signed({1'b0, sine_tab[idx_q]}) : $signed({1'b0, sine_tab[idx_q]});
      rxt_q  <= rxf_q;
    end
  end

  assign valid_o = vt_q;
  assign rx_o    = rxt_q;
  assign sine_o  = s_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[UW] |-> ({1'b0, q_q[UW]} < (QW+1)'(FourN)))
    else $error("phase quotient left the turn range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vf_q |-> ((QW+1)'(idx_q) <= (QW+1)'(SineEntries)))
    else $error("sine index beyond quarter table");

endmodule

// ----- sv/clc_light.sv -----
// Shade blend, depth products and division by the surface width, with saturation.
module clc_light (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  clc_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  input  logic signed [clc_pkg::RxW-1:0]   rx_i,
  input  logic signed [clc_pkg::SineW-1:0] sine_i,
  output logic                             valid_o,
  output logic [7:0]                       grey_shade_o,
  output logic signed [15:0]               vertex_depth_o
);
  import clc_pkg::*;

  localparam int unsigned DQ = 15;

  logic signed [16:0] a_s, sm;
  logic signed [33:0] t1_d, saf_d, t1_q, saf_q;
  logic signed [25:0] diff_d, diff_q;
  logic v1_q, v2_q, v3_q;

  assign a_s    = $signed({1'b0, cfg_i.amp});
  assign sm     = 17'(sine_i) - 17'sd16384;
  assign t1_d   = sm * a_s;
  assign saf_d  = 17'(sine_i) * a_s;
  assign diff_d = $signed({10'd0, cfg_i.width, 4'd0}) - 26'(rx_i);

  logic signed [40:0] t96;
  logic signed [13:0] shv;
  logic [7:0]         shade_d, shade2_q, shade3_q;
  logic signed [17:0] sa2_q;
  logic signed [42:0] p_d, p2_q;

  assign t96     = (41'(t1_q) <<< 6) + (41'(t1_q) <<< 5);
  assign shv     = 14'(t96 >>> 28) + 14'sd255;
  assign shade_d = shv[13] ? 8'd0 : 8'(shv);
  assign p_d     = diff_q * $signed({1'b0, cfg_i.radius});

  logic signed [21:0] ph, pl;
  logic signed [39:0] mh_d, ml_d, mh_q, ml_q;

  assign ph   = 22'(p2_q >>> 21);
  assign pl   = $signed({1'b0, p2_q[20:0]});
  assign mh_d = ph * sa2_q;
  assign ml_d = pl * sa2_q;

  logic signed [60:0] n;
  logic signed [42:0] vq;
  logic [41:0]        u;
  logic               neg_d, sat_d;

  assign n     = (61'(mh_q) <<< 21) + 61'(ml_q);
  assign vq    = 43'(n >>> 18);
  assign neg_d = vq[42];
  assign u     = neg_d ? 42'(~vq) : 42'(vq);
  assign sat_d = u[41:15] >= {15'd0, cfg_i.width};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q     <= t1_d;
      saf_q    <= saf_d;
      diff_q   <= diff_d;
      shade2_q <= shade_d;
      sa2_q    <= 18'(saf_q >>> 14);
      p2_q     <= p_d;
      shade3_q <= shade2_q;
      mh_q     <= mh_d;
      ml_q     <= ml_d;
    end
  end

  // Width divider; index 0 takes the wide sum.
  logic [11:0]   rem_q   [DQ+1];
  logic [DQ-1:0] q_q     [DQ+1];
  logic [DQ-1:0] lo_q    [DQ+1];
  logic          neg_q   [DQ+1];
  logic          sat_q   [DQ+1];
  logic [7:0]    shade_q [DQ+1];
  logic          vld_q   [DQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= u[26:15];
      lo_q[0]    <= u[14:0];
      q_q[0]     <= '0;
      neg_q[0]   <= neg_d;
      sat_q[0]   <= sat_d;
      shade_q[0] <= shade3_q;
    end
  end

  for (genvar k = 0; k < DQ; k++) begin : g_div
    logic [12:0] cand;
    logic        ge;
    assign cand = {rem_q[k], lo_q[k][DQ-1-k]};
    assign ge   = cand >= {1'b0, cfg_i.width};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]   <= ge ? 12'(cand - {1'b0, cfg_i.width}) : 12'(cand);
        q_q[k+1]     <= {q_q[k][DQ-2:0], ge};
        lo_q[k+1]    <= lo_q[k];
        neg_q[k+1]   <= neg_q[k];
        sat_q[k+1]   <= sat_q[k];
        shade_q[k+1] <= shade_q[k];
      end
    end
  end

  logic signed [15:0] depth_d, depth_q;
  logic [7:0]         shade_out_q;
  logic               vout_q;

  always_comb begin
    if (sat_q[DQ]) begin
      depth_d = neg_q[DQ] ? 16'sh8000 : 16'sh7fff;
    end else if (neg_q[DQ]) begin
      depth_d = ~$signed({1'b0, q_q[DQ]});
    end else begin
      depth_d = $signed({1'b0, q_q[DQ]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= vld_q[DQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      depth_q     <= depth_d;
      shade_out_q <= shade_q[DQ];
    end
  end

  assign valid_o        = vout_q;
  assign grey_shade_o   = shade_out_q;
  assign vertex_depth_o = depth_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && vld_q[DQ] && !sat_q[DQ]) |=> (vertex_depth_o[15] == $past(neg_q[DQ])))
    else $error("depth sign disagrees with dividend sign");

endmodule
